// ===== hw/rtl/atsl_pkg.sv =====
`timescale 1ns / 1ps
package atsl_pkg;

  localparam int MaxRegions  = 16;
  localparam int MaxSymbols  = 4096;
  localparam int RegIdxW     = $clog2(MaxRegions);
  localparam int RegCntW     = RegIdxW + 1;
  localparam int SymIdxW     = $clog2(MaxSymbols);
  localparam int SymCntW     = SymIdxW + 1;
  localparam int AddrW       = 64;
  localparam int SizeW       = 32;
  localparam int QueueDepth  = 2;
  localparam int QueueIdxW   = 1;

  localparam logic [1:0] ModeAppend = 2'd0;
  localparam logic [1:0] ModeWrite  = 2'd1;
  localparam logic [1:0] ModeLookup = 2'd2;
  localparam logic [1:0] ModeUnused = 2'd3;

  // decoded item handed from front to back
  typedef struct packed {
    logic [1:0]         mode;
    logic [AddrW-1:0]   address;
    logic [AddrW-1:0]   space_id;
    logic [AddrW-1:0]   region_end;
    logic [SymIdxW-1:0] first_symbol;
    logic [SymCntW-1:0] symbol_count;
    logic [SymIdxW-1:0] symbol_index;
    logic [SizeW-1:0]   symbol_size;
  } item_t;

  typedef struct packed {
    logic               sym_found;
    logic [SymIdxW-1:0] sym_index;
    logic               region_found;
    logic [RegIdxW-1:0] region_index;
    logic               space_seen;
  } result_t;

endpackage

// ===== hw/rtl/atsl_front.sv =====
`timescale 1ns / 1ps
module atsl_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  atsl_pkg::item_t in_item,
  output logic            q_valid,
  input  logic            q_ready,
  output atsl_pkg::item_t q_item
);
  import atsl_pkg::*;

  item_t                mem_r [QueueDepth];
  logic [QueueIdxW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QueueIdxW:0]   cnt_r, cnt_nxt;
  logic                 push, pop;

  // items of mode 3 are dropped here
  assign in_ready = (cnt_r != (QueueIdxW+1)'(QueueDepth)) || (in_item.mode == ModeUnused);
  assign push     = in_valid && in_ready && (in_item.mode != ModeUnused);
  assign q_valid  = (cnt_r != '0);
  assign q_item   = mem_r[rd_r];
  assign pop      = q_valid && q_ready;

  // queue pointers
  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + (QueueIdxW+1)'(push) - (QueueIdxW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= in_item;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QueueIdxW+1)'(QueueDepth)) else $error("queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 1'b1) else $error("queue count");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> !pop) else $error("pop from empty");
endmodule

// ===== hw/rtl/atsl_back.sv =====
`timescale 1ns / 1ps
module atsl_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_ready,
  input  atsl_pkg::item_t   q_item,
  output logic              res_valid,
  input  logic              res_ready,
  output atsl_pkg::result_t res
);
  import atsl_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StScan  = 3'd1;
  localparam logic [2:0] StRead  = 3'd2;
  localparam logic [2:0] StCmp   = 3'd3;
  localparam logic [2:0] StOut   = 3'd4;

  logic [AddrW-1:0]   rbase_r  [MaxRegions];
  logic [AddrW-1:0]   rlim_r   [MaxRegions];
  logic [AddrW-1:0]   rspace_r [MaxRegions];
  logic [SymIdxW-1:0] rfirst_r [MaxRegions];
  logic [SymCntW-1:0] rlen_r   [MaxRegions];
  logic [RegCntW-1:0] total_r;

  logic [AddrW-1:0]   sstart_m [MaxSymbols];
  logic [SizeW-1:0]   ssize_m  [MaxSymbols];
  logic [AddrW-1:0]   rd_start_r;
  logic [SizeW-1:0]   rd_size_r;

  logic [2:0]         state_r, state_nxt;
  item_t              cur_r;
  logic [RegCntW-1:0] n_r, n_nxt;
  logic [SymCntW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [SymIdxW-1:0] slot_r, slot_nxt;
  logic [SymIdxW-1:0] rfirst_cur_r, rfirst_cur_nxt;
  result_t            res_r, res_nxt;

  logic [RegIdxW-1:0] r;
  logic               sp_eq, sp_ok, rng_ok;
  logic [SymCntW-1:0] mid;
  logic [AddrW-1:0]   diff;
  logic               below, in_span;

  assign q_ready   = (state_r == StIdle);
  assign res_valid = (state_r == StOut);
  assign res       = res_r;

  assign r       = RegIdxW'(n_r - 1'b1);
  assign sp_eq   = (rspace_r[r] == cur_r.space_id);
  assign sp_ok   = sp_eq || (rspace_r[r] == '0) || (cur_r.space_id == '0);
  assign rng_ok  = (cur_r.address >= rbase_r[r]) && (cur_r.address < rlim_r[r]);
  assign mid     = SymCntW'(({1'b0, lo_r} + {1'b0, hi_r}) >> 1);
  assign diff    = cur_r.address - rd_start_r;
  assign below   = cur_r.address < rd_start_r;
  assign in_span = !below && (diff < {{(AddrW-SizeW){1'b0}}, rd_size_r});

  // sequencer: scan regions newest first, binary search each matching region until a symbol is found
  always_comb begin
    state_nxt      = state_r;
    n_nxt          = n_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    slot_nxt       = slot_r;
    rfirst_cur_nxt = rfirst_cur_r;
    res_nxt        = res_r;
    unique case (state_r)
      StIdle: begin
        if (q_valid && q_item.mode == ModeLookup) begin
          state_nxt = StScan;
          n_nxt     = total_r;
          res_nxt   = '0;
        end
      end
      StScan: begin
        if (n_r == '0) begin
          state_nxt = StOut;
        end else begin
          n_nxt = n_r - 1'b1;
          if (sp_eq) begin
            res_nxt.space_seen = 1'b1;
          end
          if (sp_ok && rng_ok) begin
            if (!res_r.region_found) begin
              res_nxt.region_found = 1'b1;
              res_nxt.region_index = r;
            end
            if (!res_r.sym_found && rlen_r[r] != '0) begin
              lo_nxt         = '0;
              hi_nxt         = rlen_r[r];
              rfirst_cur_nxt = rfirst_r[r];
              state_nxt      = StRead;
            end
          end
        end
      end
      StRead: begin
        if (lo_r < hi_r) begin
          slot_nxt  = rfirst_cur_r + mid[SymIdxW-1:0];
          state_nxt = StCmp;
        end else begin
          state_nxt = StScan;
        end
      end
      StCmp: begin
        if (below) begin
          hi_nxt    = mid;
          state_nxt = StRead;
        end else if (!in_span) begin
          lo_nxt    = mid + 1'b1;
          state_nxt = StRead;
        end else begin
          res_nxt.sym_found = 1'b1;
          res_nxt.sym_index = slot_r;
          state_nxt         = StScan;
        end
      end
      StOut: begin
        if (res_ready) begin
          state_nxt = StIdle;
        end
      end
      default: state_nxt = StIdle;
    endcase
  end

  // mid is held stable through StCmp since lo/hi do not change in StRead
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (q_valid && q_ready && q_item.mode == ModeAppend &&
          total_r != RegCntW'(MaxRegions)) begin
        total_r <= total_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r          <= n_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    slot_r       <= slot_nxt;
    rfirst_cur_r <= rfirst_cur_nxt;
    res_r        <= res_nxt;
    if (q_valid && q_ready) begin
      cur_r <= q_item;
    end
  end

  // region table
  always_ff @(posedge clk) begin
    if (q_valid && q_ready && q_item.mode == ModeAppend &&
        total_r != RegCntW'(MaxRegions)) begin
      rbase_r[total_r[RegIdxW-1:0]]  <= q_item.address;
      rlim_r[total_r[RegIdxW-1:0]]   <= q_item.region_end;
      rspace_r[total_r[RegIdxW-1:0]] <= q_item.space_id;
      rfirst_r[total_r[RegIdxW-1:0]] <= q_item.first_symbol;
      rlen_r[total_r[RegIdxW-1:0]]   <= q_item.symbol_count;
    end
  end

  // symbol store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (q_valid && q_ready && q_item.mode == ModeWrite) begin
      sstart_m[q_item.symbol_index] <= q_item.address;
      ssize_m[q_item.symbol_index]  <= q_item.symbol_size;
    end
    rd_start_r <= sstart_m[slot_nxt];
    rd_size_r  <= ssize_m[slot_nxt];
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= RegCntW'(MaxRegions)) else $error("region count overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == StOut && !res_ready) |=> state_r == StOut && $stable(res_r))
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == StCmp) |-> lo_r < hi_r) else $error("empty search window");
  assert property (@(posedge clk) disable iff (!rst_n)
    !res_r.region_found |-> !res_r.sym_found) else $error("symbol without region");
endmodule

// ===== hw/rtl/address_to_symbol_lookup_core.sv =====
`timescale 1ns / 1ps
// A lookup result is valid after the regions are scanned newest first, with a binary search
// (up to 13 steps) in each matching region until a symbol is found; each step reads
// the single symbol memory read port.
// One lookup at a time; appends and symbol writes are taken in the idle state.
// A two-entry queue decouples input acceptance from the lookup sequencer.
// Reset (rst_n low, synchronous) empties the queue and the region count; tables undefined.
module address_to_symbol_lookup_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [1:0]   in_tuser,   // mode
  // address, space_id, region_end, first_symbol, symbol_count, symbol_index,
  // symbol_size, zero pad
  input  logic [263:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // sym_found, sym_index, region_found, region_index, space_seen, zero pad
  output logic [23:0]  out_tdata
);
  import atsl_pkg::*;

  item_t   in_item, q_item;
  result_t res;
  logic    q_valid, q_ready;

  assign in_item.mode         = in_tuser;
  assign in_item.address      = in_tdata[63:0];
  assign in_item.space_id     = in_tdata[127:64];
  assign in_item.region_end   = in_tdata[191:128];
  assign in_item.first_symbol = in_tdata[203:192];
  assign in_item.symbol_count = in_tdata[216:204];
  assign in_item.symbol_index = in_tdata[228:217];
  assign in_item.symbol_size  = in_tdata[260:229];

  atsl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  atsl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {5'b0, res.space_seen, res.region_index, res.region_found,
                      res.sym_index, res.sym_found};
endmodule

// ===== tb/address_to_symbol_lookup_core_checker.sv =====
`timescale 1ns / 1ps
module address_to_symbol_lookup_core_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [1:0]   in_tuser,
  input  logic [263:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [23:0]  out_tdata,
  output int           mismatch_count,
  output int           pending_lookups,
  output int           checked_results,
  output int           symbol_hits
);
  import atsl_pkg::*;

  // shadow copy of the region table and symbol store
  logic [AddrW-1:0]   tbl_base  [MaxRegions];
  logic [AddrW-1:0]   tbl_limit [MaxRegions];
  logic [AddrW-1:0]   tbl_space [MaxRegions];
  logic [SymIdxW-1:0] tbl_first [MaxRegions];
  logic [SymCntW-1:0] tbl_len   [MaxRegions];
  int                 tbl_count;
  logic [AddrW-1:0]   sym_start [MaxSymbols];
  logic [SizeW-1:0]   sym_size  [MaxSymbols];

  result_t lookup_answers[$];

  initial begin
    mismatch_count  = 0;
    pending_lookups = 0;
    checked_results = 0;
    symbol_hits     = 0;
    tbl_count       = 0;
  end

  // binary search over one region's slice of the symbol store
  function automatic logic search_slice(int r, logic [AddrW-1:0] addr,
                                        output logic [SymIdxW-1:0] hit);
    int lo;
    int hi;
    int mid;
    logic [SymIdxW-1:0] slot;
    lo = 0;
    hi = int'(tbl_len[r]);
    hit = '0;
    while (lo < hi) begin
      mid  = (lo + hi) / 2;
      slot = SymIdxW'((int'(tbl_first[r]) + mid) % MaxSymbols);
      if (addr < sym_start[slot]) begin
        hi = mid;
      end else if ((addr - sym_start[slot]) < {32'b0, sym_size[slot]}) begin
        hit = slot;
        return 1'b1;
      end else begin
        lo = mid + 1;
      end
    end
    return 1'b0;
  endfunction

  // newest-first scan over all appended regions
  function automatic result_t resolve_address(logic [AddrW-1:0] addr,
                                              logic [AddrW-1:0] space);
    result_t res;
    logic [SymIdxW-1:0] hit;
    res = '0;
    for (int r = tbl_count - 1; r >= 0; r--) begin
      if (tbl_space[r] == space) res.space_seen = 1'b1;
      if (tbl_space[r] != 0 && space != 0 && tbl_space[r] != space) continue;
      if (addr < tbl_base[r] || addr >= tbl_limit[r]) continue;
      if (!res.region_found) begin
        res.region_found = 1'b1;
        res.region_index = RegIdxW'(r);
      end
      if (!res.sym_found && search_slice(r, addr, hit)) begin
        res.sym_found = 1'b1;
        res.sym_index = hit;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    logic [AddrW-1:0]   f_addr;
    logic [AddrW-1:0]   f_space;
    logic [SymIdxW-1:0] f_sidx;
    result_t            got;
    result_t            want;
    if (rst_n) begin
      // input transaction: update shadow state or queue a lookup answer
      if (in_tvalid && in_tready) begin
        f_addr  = in_tdata[63:0];
        f_space = in_tdata[127:64];
        f_sidx  = in_tdata[228:217];
        case (in_tuser)
          ModeAppend: begin
            if (tbl_count < MaxRegions) begin
              tbl_base[tbl_count]  = f_addr;
              tbl_space[tbl_count] = f_space;
              tbl_limit[tbl_count] = in_tdata[191:128];
              tbl_first[tbl_count] = in_tdata[203:192];
              tbl_len[tbl_count]   = in_tdata[216:204];
              tbl_count++;
            end
          end
          ModeWrite: begin
            sym_start[f_sidx] = f_addr;
            sym_size[f_sidx]  = in_tdata[260:229];
          end
          ModeLookup: begin
            lookup_answers.push_back(resolve_address(f_addr, f_space));
          end
          default: ;
        endcase
      end
      // result transaction: compare with oldest answer
      if (out_tvalid && out_tready) begin
        got = {out_tdata[0], out_tdata[12:1], out_tdata[13], out_tdata[17:14],
               out_tdata[18]};
        if (lookup_answers.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result %h at %0t", out_tdata, $realtime);
        end else begin
          want = lookup_answers.pop_front();
          checked_results++;
          if (want.sym_found) symbol_hits++;
          if (got !== want || out_tdata[23:19] !== 5'b0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"result mismatch at %0t: exp sym %b/%0d region %b/%0d seen %b,",
                        " got sym %b/%0d region %b/%0d seen %b"}, $realtime,
                       want.sym_found, want.sym_index, want.region_found,
                       want.region_index, want.space_seen, got.sym_found,
                       got.sym_index, got.region_found, got.region_index,
                       got.space_seen);
          end
        end
      end
      pending_lookups = lookup_answers.size();
    end
  end

endmodule

// ===== tb/address_to_symbol_lookup_core_test.sv =====
`timescale 1ns / 1ps
module address_to_symbol_lookup_core_test;
  import atsl_pkg::*;

  localparam int CycleLimit = 3000000;
  localparam int ItemTarget = 450;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [1:0]   in_tuser   = ModeAppend;
  logic [263:0] in_tdata   = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [23:0]  out_tdata;

  int mismatch_count;
  int pending_lookups;
  int checked_results;
  int symbol_hits;

  int  cycle_count = 0;
  int  items_sent  = 0;
  logic no_idle    = 1'b0;

  // stimulus-side bookkeeping so lookups aim at real regions
  logic [AddrW-1:0] span_lo [MaxRegions];
  logic [AddrW-1:0] span_sp [MaxRegions];
  int               regions_made = 0;
  int               appends_sent = 0;

  address_to_symbol_lookup_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  address_to_symbol_lookup_core_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tuser        (in_tuser),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .mismatch_count  (mismatch_count),
    .pending_lookups (pending_lookups),
    .checked_results (checked_results),
    .symbol_hits     (symbol_hits)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // result side backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= no_idle || ($urandom_range(99) >= 28);
    end
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // one input transaction, returns at the accepting edge
  task automatic send_item(logic [1:0] mode, logic [63:0] addr, logic [63:0] space,
                           logic [63:0] lim, logic [11:0] first, logic [12:0] count,
                           logic [11:0] sidx, logic [31:0] size);
    logic [263:0] packed_fields;
    if (!no_idle && $urandom_range(99) < 28) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    packed_fields = {3'b0, size, sidx, count, first, lim, space, addr};
    in_tuser  <= mode;
    in_tdata  <= packed_fields;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic write_symbol(logic [11:0] sidx, logic [63:0] start, logic [31:0] size);
    send_item(ModeWrite, start, rand64(), rand64(), 12'($urandom), 13'($urandom),
              sidx, size);
  endtask

  task automatic append_region(logic [63:0] base, logic [63:0] lim, logic [63:0] space,
                               logic [11:0] first, logic [12:0] count);
    send_item(ModeAppend, base, space, lim, first, count, 12'($urandom), $urandom);
    if (appends_sent < MaxRegions) begin
      span_lo[regions_made] = base;
      span_sp[regions_made] = space;
      regions_made++;
    end
    appends_sent++;
  endtask

  task automatic lookup(logic [63:0] addr, logic [63:0] space);
    send_item(ModeLookup, addr, space, rand64(), 12'($urandom), 13'($urandom),
              12'($urandom), $urandom);
  endtask

  // sorted symbols in a slice, then the region covering them
  task automatic build_region(int first, int count, logic [63:0] base, int stride,
                              logic [63:0] space);
    logic [11:0] slot;
    for (int k = 0; k < count; k++) begin
      slot = 12'((first + k) % MaxSymbols);
      write_symbol(slot, base + 64'(k) * 64'(stride) + 64'($urandom_range(0, stride / 4)),
                   32'($urandom_range(0, stride)));
    end
    append_region(base, base + 64'(count) * 64'(stride) + 64'($urandom_range(0, stride)),
                  space, 12'(first), 13'(count));
  endtask

  function automatic logic [63:0] pick_space(int r);
    case ($urandom_range(3))
      0: return 64'd0;
      1: return span_sp[$urandom_range(regions_made - 1)];
      2: return 64'($urandom_range(1, 3));
      default: return span_sp[r];
    endcase
  endfunction

  initial begin
    int r;
    int cnt;
    logic [63:0] a;
    logic [63:0] sp;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: lookups into an empty table and an unused mode
    lookup('0, '0);
    lookup('1, '1);
    send_item(ModeUnused, rand64(), rand64(), rand64(), 12'hfff, 13'h1000, 12'hfff, '1);

    // small region, empty full-range region, and a slice that wraps the store
    build_region(0, 3, 64'h1000, 64, 64'd5);
    append_region('0, '1, '0, 12'd100, 13'd0);
    write_symbol(12'd4094, 64'hffff_ffff_ffff_f000, 32'h100);
    write_symbol(12'd4095, 64'hffff_ffff_ffff_ff00, 32'h7ffff);
    append_region(64'hffff_ffff_ffff_f000, '1, 64'hffff_ffff_ffff_ffff, 12'd4094, 13'd3);

    // lookups: inside, between symbols, at the top, space mismatch and wildcard
    lookup(64'h1000 + {32'b0, 32'($urandom_range(0, 20))}, 64'd5);
    lookup(64'h1040, 64'd0);
    lookup(64'hffff_ffff_ffff_fffe, 64'hffff_ffff_ffff_ffff);
    lookup(64'hffff_ffff_ffff_fffe, 64'd7);
    lookup(64'h1000, 64'd6);
    lookup(64'h0fff, 64'd0);
    lookup(64'hffff_ffff_ffff_f010, 64'd0);

    // hold off until the block has drained everything
    in_tvalid <= 1'b0;
    while (pending_lookups != 0) @(posedge clk);

    // random part: mostly region builds and lookups aimed at them
    while (items_sent < ItemTarget) begin
      no_idle = (items_sent >= 220 && items_sent < 300);
      r = $urandom_range(99);
      if (r < 8 && appends_sent < MaxRegions) begin
        cnt = $urandom_range(0, 14);
        build_region($urandom_range(0, MaxSymbols - 1), cnt,
                     {8'($urandom_range(0, 255)), 24'b0, $urandom} & ~64'hfff,
                     $urandom_range(16, 1 << 16), pick_space(0) % 4);
      end else if (r < 70 && regions_made > 0) begin
        r  = $urandom_range(regions_made - 1);
        sp = pick_space(r);
        a  = span_lo[r] + 64'($urandom_range(0, 1 << 20)) - 64'($urandom_range(0, 3));
        lookup(a, sp);
      end else if (r < 80) begin
        lookup(rand64(), ($urandom_range(1)) ? rand64() : 64'($urandom_range(0, 3)));
      end else if (r < 90) begin
        // overwrite a store entry with random contents
        write_symbol(12'($urandom), rand64(), 32'($urandom));
      end else if (r < 95 && appends_sent >= MaxRegions) begin
        append_region(rand64(), rand64(), rand64(), 12'($urandom),
                      13'($urandom_range(0, 4096)));
      end else begin
        send_item(ModeUnused, rand64(), rand64(), rand64(), 12'($urandom), 13'($urandom),
                  12'($urandom), $urandom);
      end
    end
    in_tvalid <= 1'b0;

    // drain and let the back end settle
    while (pending_lookups != 0) @(posedge clk);
    repeat (500) @(posedge clk);

    $display("sent %0d items, %0d regions in table, %0d lookups checked, %0d symbol hits",
             items_sent, regions_made, checked_results, symbol_hits);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
